>>> rtl/core/crc_pkg.sv
`timescale 1ns / 1ps
package crc_pkg;

  localparam int SQRT_STAGES = 17;
  localparam int DIV_STAGES  = 34;
  localparam int TAIL_DEPTH  = DIV_STAGES + SQRT_STAGES;

  localparam logic [1:0] SIDE_NORTH = 2'd0;
  localparam logic [1:0] SIDE_SOUTH = 2'd1;
  localparam logic [1:0] SIDE_WEST  = 2'd2;
  localparam logic [1:0] SIDE_EAST  = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [14:0] rad;
    logic [1:0]  side;
    logic        neg_x;
    logic        neg_y;
    logic [35:0] cx2;
    logic [35:0] cy2;
    logic [35:0] s;
    logic [32:0] d2;
  } front_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [17:0] depth;
    logic [1:0]  side;
    logic        neg_x;
    logic        neg_y;
    logic [35:0] cx2;
    logic [35:0] cy2;
    logic [35:0] s;
  } depth_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [17:0] depth;
    logic [1:0]  side;
    logic        flip_x;
    logic        flip_y;
    logic        s_zero;
  } tail_t;

endpackage

>>> rtl/core/circle_rect_collision.sv
`timescale 1ns / 1ps
// Circle against axis-aligned rectangle collision, signed Q11.4 coordinates.
// Input channel: pair_valid / pair_stall with the circle and rectangle fields;
// a beat is taken when pair_valid is high and pair_stall low.
// Output channel: result_valid / result_stall with hit, overlap_depth,
// push_x, push_y and hit_side, one result beat per input beat, in order.
// The pipeline has 3 front stages, a 17 stage distance square root,
// 4 stages for depth and products, a 34 stage divider, a 17 stage square
// root for the push scale and the output register.
// Throughput is one beat per cycle unless stalled; every stage is a plain register.
// When result_valid is high and result_stall high the whole pipeline holds,
// pair_stall rises in the same cycle and nothing is lost or repeated.
// Reset clears all valid bits; no result is presented until a beat goes in.
module circle_rect_collision (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [15:0] circle_x,
  input  logic signed [15:0] circle_y,
  input  logic        [14:0] circle_radius,
  input  logic signed [15:0] rect_left,
  input  logic signed [15:0] rect_top,
  input  logic        [14:0] rect_width,
  input  logic        [14:0] rect_height,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               hit,
  output logic signed [17:0] overlap_depth,
  output logic signed [18:0] push_x,
  output logic signed [18:0] push_y,
  output logic        [1:0]  hit_side
);

  localparam int NS = crc_pkg::SQRT_STAGES;
  localparam int NT = crc_pkg::TAIL_DEPTH;

  logic en;
  assign en         = !(result_valid && result_stall);
  assign pair_stall = !en;

  crc_pkg::front_t front;

  crc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .valid         (pair_valid),
    .circle_x      (circle_x),
    .circle_y      (circle_y),
    .circle_radius (circle_radius),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .front         (front)
  );

  // distance
  logic [16:0] dist_root;
  logic        dist_nz;

  crc_isqrt u_dist (
    .clk    (clk),
    .en     (en),
    .n      ({1'b0, front.d2}),
    .root   (dist_root),
    .rem_nz (dist_nz)
  );

  crc_pkg::front_t fline [NS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        fline[i].valid <= 1'b0;
      end else if (en) begin
        fline[i] <= (i == 0) ? front : fline[(i == 0) ? 0 : i - 1];
      end
    end
  end

  crc_pkg::front_t fa;
  logic [17:0] dist_up;
  assign fa      = fline[NS-1];
  assign dist_up = {1'b0, dist_root} + {17'd0, fa.hit & dist_nz};

  // depth
  crc_pkg::depth_t dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp.valid <= 1'b0;
    end else if (en) begin
      dp.valid <= fa.valid;
    end
    if (en) begin
      dp.hit   <= fa.hit;
      dp.depth <= {3'b000, fa.rad} - dist_up;
      dp.side  <= fa.side;
      dp.neg_x <= fa.neg_x;
      dp.neg_y <= fa.neg_y;
      dp.cx2   <= fa.cx2;
      dp.cy2   <= fa.cy2;
      dp.s     <= fa.s;
    end
  end

  // depth squared, then products split in halves
  logic [16:0] dmag;
  assign dmag = dp.depth[17] ? 17'(-dp.depth) : dp.depth[16:0];

  crc_pkg::depth_t m1, m2, m3;
  logic [33:0] dd;
  logic [51:0] pxl, pxh, pyl, pyh;
  logic [69:0] rx, ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
      m2.valid <= 1'b0;
      m3.valid <= 1'b0;
    end else if (en) begin
      m1 <= dp;
      m2 <= m1;
      m3 <= m2;
    end
    if (en) begin
      dd  <= dmag * dmag;
      pxl <= dd * m1.cx2[17:0];
      pxh <= dd * m1.cx2[35:18];
      pyl <= dd * m1.cy2[17:0];
      pyh <= dd * m1.cy2[35:18];
      rx  <= {18'd0, pxl} + {pxh, 18'd0};
      ry  <= {18'd0, pyl} + {pyh, 18'd0};
    end
  end

  // quotient and its square root
  logic [33:0] qx, qy;
  logic [16:0] sx, sy;
  logic        nzx, nzy;

  crc_div u_div_x (.clk(clk), .en(en), .dividend(rx), .divisor(m3.s), .quotient(qx));
  crc_div u_div_y (.clk(clk), .en(en), .dividend(ry), .divisor(m3.s), .quotient(qy));

  crc_isqrt u_scale_x (.clk(clk), .en(en), .n(qx), .root(sx), .rem_nz(nzx));
  crc_isqrt u_scale_y (.clk(clk), .en(en), .n(qy), .root(sy), .rem_nz(nzy));

  crc_pkg::tail_t tin;
  crc_pkg::tail_t tline [NT];

  always_comb begin
    tin.valid  = m3.valid;
    tin.hit    = m3.hit;
    tin.depth  = m3.depth;
    tin.side   = m3.side;
    tin.flip_x = m3.depth[17] != m3.neg_x;
    tin.flip_y = m3.depth[17] != m3.neg_y;
    tin.s_zero = m3.s == '0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NT; i++) begin
      if (rst) begin
        tline[i].valid <= 1'b0;
      end else if (en) begin
        tline[i] <= (i == 0) ? tin : tline[(i == 0) ? 0 : i - 1];
      end
    end
  end

  crc_pkg::tail_t ta;
  logic [18:0] ux, uy;
  assign ta = tline[NT-1];
  assign ux = {2'b00, sx};
  assign uy = {2'b00, sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= ta.valid;
    end
    if (en) begin
      hit           <= ta.hit;
      overlap_depth <= ta.depth;
      hit_side      <= ta.side;
      push_x        <= ta.s_zero ? '0 : (ta.flip_x ? -ux : ux);
      push_y        <= ta.s_zero ? '0 : (ta.flip_y ? -uy : uy);
    end
  end

  logic unused;
  assign unused = nzx ^ nzy;

endmodule

>>> rtl/core/crc_front.sv
`timescale 1ns / 1ps
module crc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  logic signed [15:0]  circle_x,
  input  logic signed [15:0]  circle_y,
  input  logic        [14:0]  circle_radius,
  input  logic signed [15:0]  rect_left,
  input  logic signed [15:0]  rect_top,
  input  logic        [14:0]  rect_width,
  input  logic        [14:0]  rect_height,
  output crc_pkg::front_t     front
);

  logic signed [17:0] cx, cy, left, top, right, bottom, nx, ny, dx, dy;
  logic signed [18:0] vx_c, vy_c;
  logic        [15:0] ax_c, ay_c;
  logic        [1:0]  side_c;

  always_comb begin
    cx     = 18'(circle_x);
    cy     = 18'(circle_y);
    left   = 18'(rect_left);
    top    = 18'(rect_top);
    right  = left + $signed({3'b000, rect_width});
    bottom = top + $signed({3'b000, rect_height});
    nx = (cx < left) ? left : ((cx > right) ? right : cx);
    ny = (cy < top) ? top : ((cy > bottom) ? bottom : cy);
    dx = cx - nx;
    dy = cy - ny;
    ax_c = dx[17] ? 16'(-dx) : dx[15:0];
    ay_c = dy[17] ? 16'(-dy) : dy[15:0];
    vx_c = 19'(cx) * 19'sd2 - (19'(left) * 19'sd2 + $signed({4'b0000, rect_width}));
    vy_c = 19'(cy) * 19'sd2 - (19'(top) * 19'sd2 + $signed({4'b0000, rect_height}));
    priority if (cy < top) begin
      side_c = crc_pkg::SIDE_NORTH;
    end else if (cy > bottom) begin
      side_c = crc_pkg::SIDE_SOUTH;
    end else if (cx < left) begin
      side_c = crc_pkg::SIDE_WEST;
    end else begin
      side_c = crc_pkg::SIDE_EAST;
    end
  end

  // stage 1: clamp and offsets
  logic               v1;
  logic        [15:0] ax, ay;
  logic signed [18:0] vx, vy;
  logic        [14:0] rad1;
  logic        [1:0]  side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
    end
    if (en) begin
      ax    <= ax_c;
      ay    <= ay_c;
      vx    <= vx_c;
      vy    <= vy_c;
      rad1  <= circle_radius;
      side1 <= side_c;
    end
  end

  // stage 2: squares
  logic        [17:0] mx, my;
  logic               v2;
  logic        [31:0] ax2, ay2;
  logic        [29:0] r2;
  logic        [35:0] vx2, vy2;
  logic               neg_x2, neg_y2;
  logic        [14:0] rad2;
  logic        [1:0]  side2;

  assign mx = vx[18] ? 18'(-vx) : vx[17:0];
  assign my = vy[18] ? 18'(-vy) : vy[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ax2    <= ax * ax;
      ay2    <= ay * ay;
      r2     <= rad1 * rad1;
      vx2    <= mx * mx;
      vy2    <= my * my;
      neg_x2 <= vx[18];
      neg_y2 <= vy[18];
      rad2   <= rad1;
      side2  <= side1;
    end
  end

  // stage 3: sums and hit test
  logic [32:0] d2_c;
  assign d2_c = {1'b0, ax2} + {1'b0, ay2};

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front.valid <= v2;
    end
    if (en) begin
      front.hit   <= d2_c < {3'b000, r2};
      front.rad   <= rad2;
      front.side  <= side2;
      front.neg_x <= neg_x2;
      front.neg_y <= neg_y2;
      front.cx2   <= vx2;
      front.cy2   <= vy2;
      front.s     <= vx2 + vy2;
      front.d2    <= d2_c;
    end
  end

endmodule

>>> rtl/core/crc_isqrt.sv
`timescale 1ns / 1ps
module crc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] n,
  output logic [16:0] root,
  output logic        rem_nz
);

  localparam int N = crc_pkg::SQRT_STAGES;

  logic [33:0] rest [N];
  logic [18:0] rem  [N];
  logic [16:0] rt   [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [33:0] rest_in;
      logic [18:0] rem_in;
      logic [16:0] rt_in;
      logic [19:0] r2;
      logic [19:0] trial;
      logic        ge;
      if (k == 0) begin : g_first
        assign rest_in = n;
        assign rem_in  = '0;
        assign rt_in   = '0;
      end else begin : g_next
        assign rest_in = rest[k-1];
        assign rem_in  = rem[k-1];
        assign rt_in   = rt[k-1];
      end
      assign r2    = {rem_in[17:0], rest_in[33:32]};
      assign trial = {1'b0, rt_in, 2'b01};
      assign ge    = r2 >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          rest[k] <= {rest_in[31:0], 2'b00};
          rem[k]  <= ge ? 19'(r2 - trial) : r2[18:0];
          rt[k]   <= {rt_in[15:0], ge};
        end
      end
    end
  endgenerate

  assign root   = rt[N-1];
  assign rem_nz = rem[N-1] != '0;

endmodule

>>> rtl/core/crc_div.sv
`timescale 1ns / 1ps
module crc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [69:0] dividend,
  input  logic [35:0] divisor,
  output logic [33:0] quotient
);

  localparam int N = crc_pkg::DIV_STAGES;

  logic [35:0] rem [N];
  logic [33:0] low [N];
  logic [33:0] quo [N];
  logic [35:0] dsr [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [35:0] rem_in, dsr_in;
      logic [33:0] low_in, quo_in;
      logic [36:0] r2;
      logic        ge;
      if (k == 0) begin : g_first
        assign rem_in = dividend[69:34];
        assign low_in = dividend[33:0];
        assign quo_in = '0;
        assign dsr_in = divisor;
      end else begin : g_next
        assign rem_in = rem[k-1];
        assign low_in = low[k-1];
        assign quo_in = quo[k-1];
        assign dsr_in = dsr[k-1];
      end
      assign r2 = {rem_in, low_in[33]};
      assign ge = r2 >= {1'b0, dsr_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? 36'(r2 - {1'b0, dsr_in}) : r2[35:0];
          low[k] <= {low_in[32:0], 1'b0};
          quo[k] <= {quo_in[32:0], ge};
          dsr[k] <= dsr_in;
        end
      end
    end
  endgenerate

  assign quotient = quo[N-1];

endmodule
